@@ src/afbd_pkg.sv @@
// ----------------------------------------------------------------------------
// afbd_pkg: shared types and constants of the anchor-free box decoder
// Field widths, configuration register codes, queue sizing and helpers.
// ----------------------------------------------------------------------------
package afbd_pkg;

    localparam int COORD_FRAC_BITS = 4;
    localparam int SCORE_FRAC_BITS = 12;

    localparam int CLASS_W    = 8;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 10;
    localparam int FEAT_W     = 11;
    localparam int STRIDE_W   = 8;
    localparam int IMG_W      = 13;
    localparam int DIST_W     = 16;
    localparam int SCORE_W    = 16;
    localparam int BOX_W      = 16;
    localparam int PROD_W     = 2 * SCORE_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // cell center: col*stride << frac plus half a stride
    localparam int CX_W   = COL_W + STRIDE_W + COORD_FRAC_BITS + 1;
    localparam int HALF_W = STRIDE_W + COORD_FRAC_BITS;
    localparam int EDGE_W = CX_W + 2;
    localparam int LIM_W  = IMG_W + COORD_FRAC_BITS + 4;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_STRIDE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 3'd5;

    localparam logic [CLASS_W-1:0]  RST_CLASS_COUNT    = 8'd80;
    localparam logic [FEAT_W-1:0]   RST_FEATURE_HEIGHT = 11'd1;
    localparam logic [FEAT_W-1:0]   RST_FEATURE_WIDTH  = 11'd1;
    localparam logic [STRIDE_W-1:0] RST_CELL_STRIDE    = 8'd8;
    localparam logic [IMG_W-1:0]    RST_FRAME_WIDTH    = 13'd4096;
    localparam logic [IMG_W-1:0]    RST_FRAME_HEIGHT   = 13'd4096;

    localparam logic [CLASS_W:0] CLASS_MAX = (CLASS_W + 1)'((1 << CLASS_W) - 1);
    localparam logic [FEAT_W-1:0] COL_MAX  = FEAT_W'((1 << COL_W) - 1);
    localparam logic [FEAT_W-1:0] ROW_MAX  = FEAT_W'((1 << ROW_W) - 1);

    localparam logic [LIM_W-1:0] BOX_MAX = LIM_W'((1 << BOX_W) - 1);
    localparam logic signed [PROD_W-1:0] SCORE_HI = PROD_W'((1 << (SCORE_W - 1)) - 1);
    localparam logic signed [PROD_W-1:0] SCORE_LO = -PROD_W'(1 << (SCORE_W - 1));

    typedef struct packed {
        logic [CLASS_W-1:0]  class_count;
        logic [FEAT_W-1:0]   feature_height;
        logic [FEAT_W-1:0]   feature_width;
        logic [STRIDE_W-1:0] cell_stride;
        logic [IMG_W-1:0]    frame_width;
        logic [IMG_W-1:0]    frame_height;
    } t_cfg;

    typedef struct packed {
        logic signed [DIST_W-1:0]  dist_left;
        logic signed [DIST_W-1:0]  dist_top;
        logic signed [DIST_W-1:0]  dist_right;
        logic signed [DIST_W-1:0]  dist_bottom;
        logic signed [SCORE_W-1:0] center_score;
        logic signed [SCORE_W-1:0] cls_score;
        logic [CX_W-1:0]           cx;
        logic [CX_W-1:0]           cy;
        logic [CLASS_W-1:0]        class_index;
        logic                      image_done;
    } t_item;

    // upper clamp: (size - 1) << frac, a zero size acts as one, capped to the box range
    function automatic logic [BOX_W-1:0] clamp_limit(input logic [IMG_W-1:0] size);
        logic [IMG_W-1:0] size_m1;
        logic [LIM_W-1:0] lim;
        size_m1 = (size == '0) ? '0 : size - IMG_W'(1);
        lim     = LIM_W'(size_m1) << COORD_FRAC_BITS;
        if (lim > BOX_MAX) begin
            return BOX_W'(BOX_MAX);
        end
        return BOX_W'(lim);
    endfunction

    function automatic logic [BOX_W-1:0] clamp_edge(
        input logic signed [EDGE_W-1:0] v,
        input logic [BOX_W-1:0]         hi
    );
        logic signed [EDGE_W-1:0] hi_ext;
        hi_ext = $signed({{(EDGE_W - BOX_W){1'b0}}, hi});
        if (v < 0) begin
            return '0;
        end
        if (v > hi_ext) begin
            return hi;
        end
        return BOX_W'(v);
    endfunction

endpackage

@@ src/anchor_free_box_decode_core.sv @@
// ----------------------------------------------------------------------------
// anchor_free_box_decode_core: anchor-free box decoder
// Turns per-location edge distances and scores into clamped boxes.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (i_in_valid / o_in_ready) takes one item per feature
//   location and class, raster order, classes innermost. Each transfer gives
//   one result on the output channel (o_out_valid / i_out_ready): the box,
//   its class index, a ranking score and an end-of-image flag.
//   Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data,
//   one register per cycle; the user must write it only while no item is in flight, which the block does not enforce.
//   Throughput is one item per cycle while the queue is not full. A result
//   passes from its input transfer through the item queue and the clamp and
//   multiply stage into the output register.
//   A four-entry queue sits between the counter front end and the datapath,
//   so o_in_ready stays high while the receiver stalls until the queue fills.
//   Reset clears the class, column and row counters, empties the queue and
//   pipeline, and loads the register defaults (80 classes, a 1x1 map,
//   stride 8, a 4096x4096 image).
// ----------------------------------------------------------------------------
module anchor_free_box_decode_core
    import afbd_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic signed [DIST_W-1:0]  i_dist_left,
    input  logic signed [DIST_W-1:0]  i_dist_top,
    input  logic signed [DIST_W-1:0]  i_dist_right,
    input  logic signed [DIST_W-1:0]  i_dist_bottom,
    input  logic signed [SCORE_W-1:0] i_center_score,
    input  logic signed [SCORE_W-1:0] i_cls_score,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [BOX_W-1:0]          o_box_left,
    output logic [BOX_W-1:0]          o_box_top,
    output logic [BOX_W-1:0]          o_box_right,
    output logic [BOX_W-1:0]          o_box_bottom,
    output logic signed [SCORE_W-1:0] o_rank_score,
    output logic [CLASS_W-1:0]        o_class_index,
    output logic                      o_image_done
);

    t_cfg  cfg;
    logic  push_valid;
    logic  push_ready;
    t_item push_item;
    logic  pop_valid;
    logic  pop_ready;
    t_item pop_item;

    afbd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    afbd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_dist_left    (i_dist_left),
        .i_dist_top     (i_dist_top),
        .i_dist_right   (i_dist_right),
        .i_dist_bottom  (i_dist_bottom),
        .i_center_score (i_center_score),
        .i_cls_score    (i_cls_score),
        .o_push_valid   (push_valid),
        .i_push_ready   (push_ready),
        .o_push_item    (push_item)
    );

    afbd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_item  (push_item),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_item   (pop_item)
    );

    afbd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_item_valid  (pop_valid),
        .o_item_ready  (pop_ready),
        .i_item        (pop_item),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_box_left    (o_box_left),
        .o_box_top     (o_box_top),
        .o_box_right   (o_box_right),
        .o_box_bottom  (o_box_bottom),
        .o_rank_score  (o_rank_score),
        .o_class_index (o_class_index),
        .o_image_done  (o_image_done)
    );

endmodule

@@ src/afbd_cfg.sv @@
// ----------------------------------------------------------------------------
// afbd_cfg: configuration registers
// Write-only register file, one register per index.
// ----------------------------------------------------------------------------
module afbd_cfg
    import afbd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CLASS_COUNT:    n_cfg.class_count    = i_cfg_data[CLASS_W-1:0];
                CFG_FEATURE_HEIGHT: n_cfg.feature_height = i_cfg_data[FEAT_W-1:0];
                CFG_FEATURE_WIDTH:  n_cfg.feature_width  = i_cfg_data[FEAT_W-1:0];
                CFG_CELL_STRIDE:    n_cfg.cell_stride    = i_cfg_data[STRIDE_W-1:0];
                CFG_FRAME_WIDTH:    n_cfg.frame_width    = i_cfg_data[IMG_W-1:0];
                CFG_FRAME_HEIGHT:   n_cfg.frame_height   = i_cfg_data[IMG_W-1:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.class_count    <= RST_CLASS_COUNT;
            r_cfg.feature_height <= RST_FEATURE_HEIGHT;
            r_cfg.feature_width  <= RST_FEATURE_WIDTH;
            r_cfg.cell_stride    <= RST_CELL_STRIDE;
            r_cfg.frame_width    <= RST_FRAME_WIDTH;
            r_cfg.frame_height   <= RST_FRAME_HEIGHT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ src/afbd_front.sv @@
// ----------------------------------------------------------------------------
// afbd_front: input side of the decoder
// Tracks class, column and row of each item and forms the cell center.
// ----------------------------------------------------------------------------
module afbd_front
    import afbd_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cfg                      i_cfg,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic signed [DIST_W-1:0]  i_dist_left,
    input  logic signed [DIST_W-1:0]  i_dist_top,
    input  logic signed [DIST_W-1:0]  i_dist_right,
    input  logic signed [DIST_W-1:0]  i_dist_bottom,
    input  logic signed [SCORE_W-1:0] i_center_score,
    input  logic signed [SCORE_W-1:0] i_cls_score,
    output logic                      o_push_valid,
    input  logic                      i_push_ready,
    output t_item                     o_push_item
);

    logic [CLASS_W-1:0] r_class_now;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic [CLASS_W-1:0] n_class_now;
    logic [COL_W-1:0]   n_col;
    logic [ROW_W-1:0]   n_row;

    logic                        accept;
    logic [CLASS_W:0]            cls_next;
    logic [FEAT_W-1:0]           col_next;
    logic [FEAT_W-1:0]           row_next;
    logic                        cls_wrap;
    logic                        col_wrap;
    logic                        row_wrap;
    logic [COL_W+STRIDE_W-1:0]   prod_x;
    logic [ROW_W+STRIDE_W-1:0]   prod_y;
    logic [HALF_W-1:0]           half;

    assign accept = i_in_valid && i_push_ready;

    assign cls_next = {1'b0, r_class_now} + (CLASS_W + 1)'(1);
    assign col_next = {1'b0, r_col} + FEAT_W'(1);
    assign row_next = {1'b0, r_row} + FEAT_W'(1);

    assign cls_wrap = (cls_next >= {1'b0, i_cfg.class_count}) || (cls_next > CLASS_MAX);
    assign col_wrap = (col_next >= i_cfg.feature_width) || (col_next > COL_MAX);
    assign row_wrap = (row_next >= i_cfg.feature_height) || (row_next > ROW_MAX);

    // outer counter steps only when the inner one wraps
    always_comb begin
        n_class_now = r_class_now;
        n_col       = r_col;
        n_row       = r_row;
        if (accept) begin
            if (!cls_wrap) begin
                n_class_now = cls_next[CLASS_W-1:0];
            end else begin
                n_class_now = '0;
                if (!col_wrap) begin
                    n_col = col_next[COL_W-1:0];
                end else begin
                    n_col = '0;
                    n_row = row_wrap ? '0 : row_next[ROW_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class_now <= '0;
            r_col       <= '0;
            r_row       <= '0;
        end else begin
            r_class_now <= n_class_now;
            r_col       <= n_col;
            r_row       <= n_row;
        end
    end

    assign prod_x = (COL_W + STRIDE_W)'(r_col) * (COL_W + STRIDE_W)'(i_cfg.cell_stride);
    assign prod_y = (ROW_W + STRIDE_W)'(r_row) * (ROW_W + STRIDE_W)'(i_cfg.cell_stride);
    assign half   = (HALF_W'(i_cfg.cell_stride) << COORD_FRAC_BITS) >> 1;

    always_comb begin
        o_push_item.dist_left    = i_dist_left;
        o_push_item.dist_top     = i_dist_top;
        o_push_item.dist_right   = i_dist_right;
        o_push_item.dist_bottom  = i_dist_bottom;
        o_push_item.center_score = i_center_score;
        o_push_item.cls_score    = i_cls_score;
        o_push_item.cx           = (CX_W'(prod_x) << COORD_FRAC_BITS) + CX_W'(half);
        o_push_item.cy           = (CX_W'(prod_y) << COORD_FRAC_BITS) + CX_W'(half);
        o_push_item.class_index  = r_class_now;
        o_push_item.image_done   = cls_wrap && col_wrap && row_wrap;
    end

    assign o_push_valid = i_in_valid;
    assign o_in_ready   = i_push_ready;

endmodule

@@ src/afbd_queue.sv @@
// ----------------------------------------------------------------------------
// afbd_queue: short item queue between the front and back parts
// Register FIFO, head entry shown on the pop side.
// ----------------------------------------------------------------------------
module afbd_queue
    import afbd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    output logic  o_push_ready,
    input  t_item i_push_item,
    output logic  o_pop_valid,
    input  logic  i_pop_ready,
    output t_item o_pop_item
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_count;

    logic push;
    logic pop;

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_item   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
        end
        case ({push, pop})
            2'b10:   n_count = r_count + QCNT_W'(1);
            2'b01:   n_count = r_count - QCNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    // fill level and pointer distance must agree
    a_count_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == QCNT_W'(QUEUE_DEPTH)) || (r_wr_ptr != r_rd_ptr))
        else $error("queue count disagrees with pointers");

endmodule

@@ src/afbd_back.sv @@
// ----------------------------------------------------------------------------
// afbd_back: box and score datapath
// Stage one forms and clamps the edges and multiplies the scores, stage two
// rounds, saturates and zeroes the score of an inverted box into the output.
// ----------------------------------------------------------------------------
module afbd_back
    import afbd_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cfg                      i_cfg,
    input  logic                      i_item_valid,
    output logic                      o_item_ready,
    input  t_item                     i_item,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [BOX_W-1:0]          o_box_left,
    output logic [BOX_W-1:0]          o_box_top,
    output logic [BOX_W-1:0]          o_box_right,
    output logic [BOX_W-1:0]          o_box_bottom,
    output logic signed [SCORE_W-1:0] o_rank_score,
    output logic [CLASS_W-1:0]        o_class_index,
    output logic                      o_image_done
);

    logic                     r_s1_valid;
    logic [BOX_W-1:0]         r_s1_left;
    logic [BOX_W-1:0]         r_s1_top;
    logic [BOX_W-1:0]         r_s1_right;
    logic [BOX_W-1:0]         r_s1_bottom;
    logic signed [PROD_W-1:0] r_s1_prod;
    logic [CLASS_W-1:0]       r_s1_class;
    logic                     r_s1_done;

    logic                      r_out_valid;
    logic [BOX_W-1:0]          r_out_left;
    logic [BOX_W-1:0]          r_out_top;
    logic [BOX_W-1:0]          r_out_right;
    logic [BOX_W-1:0]          r_out_bottom;
    logic signed [SCORE_W-1:0] r_out_score;
    logic [CLASS_W-1:0]        r_out_class;
    logic                      r_out_done;

    logic                      out_adv;
    logic                      s1_load;
    logic [BOX_W-1:0]          lim_x;
    logic [BOX_W-1:0]          lim_y;
    logic signed [EDGE_W-1:0]  e_left;
    logic signed [EDGE_W-1:0]  e_top;
    logic signed [EDGE_W-1:0]  e_right;
    logic signed [EDGE_W-1:0]  e_bottom;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  shifted;
    logic signed [SCORE_W-1:0] sat_score;
    logic                      inverted;

    assign out_adv      = !r_out_valid || i_out_ready;
    assign o_item_ready = !r_s1_valid || out_adv;
    assign s1_load      = o_item_ready;

    assign lim_x = clamp_limit(i_cfg.frame_width);
    assign lim_y = clamp_limit(i_cfg.frame_height);

    assign e_left   = $signed({2'b00, i_item.cx}) - EDGE_W'($signed(i_item.dist_left));
    assign e_top    = $signed({2'b00, i_item.cy}) - EDGE_W'($signed(i_item.dist_top));
    assign e_right  = $signed({2'b00, i_item.cx}) + EDGE_W'($signed(i_item.dist_right));
    assign e_bottom = $signed({2'b00, i_item.cy}) + EDGE_W'($signed(i_item.dist_bottom));
    assign prod     = PROD_W'($signed(i_item.center_score)) *
                      PROD_W'($signed(i_item.cls_score));

    // arithmetic shift rounds toward minus infinity
    assign shifted = r_s1_prod >>> SCORE_FRAC_BITS;

    always_comb begin
        if (shifted > SCORE_HI) begin
            sat_score = SCORE_W'(SCORE_HI);
        end else if (shifted < SCORE_LO) begin
            sat_score = SCORE_W'(SCORE_LO);
        end else begin
            sat_score = SCORE_W'(shifted);
        end
    end

    assign inverted = (r_s1_right < r_s1_left) || (r_s1_bottom < r_s1_top);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_load) begin
                r_s1_valid <= i_item_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load && i_item_valid) begin
            r_s1_left   <= clamp_edge(e_left, lim_x);
            r_s1_top    <= clamp_edge(e_top, lim_y);
            r_s1_right  <= clamp_edge(e_right, lim_x);
            r_s1_bottom <= clamp_edge(e_bottom, lim_y);
            r_s1_prod   <= prod;
            r_s1_class  <= i_item.class_index;
            r_s1_done   <= i_item.image_done;
        end
        if (out_adv && r_s1_valid) begin
            r_out_left   <= r_s1_left;
            r_out_top    <= r_s1_top;
            r_out_right  <= r_s1_right;
            r_out_bottom <= r_s1_bottom;
            r_out_score  <= inverted ? '0 : sat_score;
            r_out_class  <= r_s1_class;
            r_out_done   <= r_s1_done;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_box_left    = r_out_left;
    assign o_box_top     = r_out_top;
    assign o_box_right   = r_out_right;
    assign o_box_bottom  = r_out_bottom;
    assign o_rank_score  = r_out_score;
    assign o_class_index = r_out_class;
    assign o_image_done  = r_out_done;

    a_score_box_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_score != '0) |->
            (r_out_right >= r_out_left && r_out_bottom >= r_out_top))
        else $error("nonzero score on inverted box");

    a_clamp_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_left <= lim_x && r_out_right <= lim_x))
        else $error("horizontal edge beyond clamp");

    a_clamp_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_top <= lim_y && r_out_bottom <= lim_y))
        else $error("vertical edge beyond clamp");

endmodule
